FILE: hdl/yrz_pkg.sv
package yrz_pkg;

    // Largest number of copies emitted for one pixel.
    localparam int MAX_ZOOM = 10;
    localparam int COPY_W   = $clog2(MAX_ZOOM + 1);
    localparam int ZOOM_W   = 4;

    // Width of the fixed-point channel sums, sign included.
    localparam int SUM_W = 33;

    // Matrix coefficients: Y_COEF has 20 fractional bits, the others 10 each.
    localparam logic signed [SUM_W-1:0] Y_COEF   = 33'sd1225732;
    localparam logic signed [SUM_W-1:0] C_COEF   = 33'sd1170;
    localparam logic signed [SUM_W-1:0] R_CR     = 33'sd1436;
    localparam logic signed [SUM_W-1:0] G_CB     = 33'sd352;
    localparam logic signed [SUM_W-1:0] G_CR     = 33'sd731;
    localparam logic signed [SUM_W-1:0] B_CB     = 33'sd1815;
    localparam logic [8:0]              Y_OFFSET = 9'd16;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic load;      // capture the input word
        logic scale;     // offset and scale luma and chroma
        logic product;   // form the matrix products
        logic sum;       // add, clamp and pack
    } yrz_cmd_t;

endpackage

FILE: hdl/ycbcr_to_rgb565_zoom_top.sv
// Converts one YCbCr pixel word into an RGB565 pixel and sends it out zoom
// times, the final copy marked by m_last_copy and, for a line's last pixel,
// by m_line_done. Chroma is latched on even columns and reused on the odd
// column that follows; the column count restarts after end of line. One word
// occupies the block from the accepting cycle through the scale, product
// and sum stages of the datapath to the output, which sends N copies, N
// being the copy count (zoom, with zero read as one and values above ten
// read as ten), and holds each copy until it is taken. The zoom register
// may be written through cfg_data at any time the block is idle; it resets
// to one.
module ycbcr_to_rgb565_zoom_top
    import yrz_pkg::*;
(
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              cfg_valid,
    output logic              cfg_ready,
    input  logic [ZOOM_W-1:0] cfg_data,
    input  logic              s_valid,
    output logic              s_ready,
    input  logic [7:0]        s_luma,
    input  logic [7:0]        s_chroma_blue,
    input  logic [7:0]        s_chroma_red,
    input  logic              s_end_of_line,
    output logic              m_valid,
    input  logic              m_ready,
    output logic [15:0]       m_rgb_pixel,
    output logic              m_last_copy,
    output logic              m_line_done
);

    yrz_cmd_t cmd;
    logic     last_copy;

    // Sequencer and zoom register.
    yrz_controller u_controller (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .last_copy (last_copy),
        .cmd       (cmd)
    );

    // Colour conversion stages.
    yrz_datapath u_datapath (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cmd         (cmd),
        .last_copy   (last_copy),
        .luma        (s_luma),
        .chroma_blue (s_chroma_blue),
        .chroma_red  (s_chroma_red),
        .end_of_line (s_end_of_line),
        .rgb_pixel   (m_rgb_pixel),
        .line_done   (m_line_done)
    );

    assign m_last_copy = last_copy;

endmodule

FILE: hdl/yrz_datapath.sv
module yrz_datapath
    import yrz_pkg::*;
(
    input  logic       aclk,
    input  logic       aresetn,
    input  yrz_cmd_t   cmd,
    input  logic       last_copy,
    input  logic [7:0] luma,
    input  logic [7:0] chroma_blue,
    input  logic [7:0] chroma_red,
    input  logic       end_of_line,
    output logic [15:0] rgb_pixel,
    output logic       line_done
);

    logic                    odd_reg, odd_next;
    logic [7:0]              held_blue_reg, held_red_reg;
    logic [7:0]              luma_reg;
    logic                    eol_reg;
    logic signed [SUM_W-1:0] y1_reg, pb_reg, pr_reg;
    logic signed [SUM_W-1:0] y1d_reg, rcr_reg, gcb_reg, gcr_reg, bcb_reg;
    logic [15:0]             pix_reg;
    logic signed [8:0]       luma_off;
    logic signed [7:0]       cb_off, cr_off;
    logic signed [SUM_W-1:0] r_sum, g_sum, b_sum;
    logic [7:0]              r_ch, g_ch, b_ch;

    // Clamp a fixed-point sum to 0..255 after the shift by twenty.
    function automatic logic [7:0] to_channel(input logic signed [SUM_W-1:0] s);
        logic [7:0] c;
        if (s[SUM_W-1]) begin
            c = 8'd0;
        end else if (|s[SUM_W-2:28]) begin
            c = 8'hFF;
        end else begin
            c = s[27:20];
        end
        return c;
    endfunction

    // Column parity flips each pixel and restarts at the end of a line.
    assign odd_next = end_of_line ? 1'b0 : ~odd_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            odd_reg       <= 1'b0;
            held_blue_reg <= 8'd0;
            held_red_reg  <= 8'd0;
        end else if (cmd.load) begin
            odd_reg <= odd_next;
            if (!odd_reg) begin
                held_blue_reg <= chroma_blue;
                held_red_reg  <= chroma_red;
            end
        end
    end

    // Capture of the input word.
    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            luma_reg <= luma;
            eol_reg  <= end_of_line;
        end
    end

    // Offsets: flipping the top bit of a chroma byte subtracts 128.
    assign luma_off = $signed({1'b0, luma_reg} - Y_OFFSET);
    assign cb_off   = $signed({~held_blue_reg[7], held_blue_reg[6:0]});
    assign cr_off   = $signed({~held_red_reg[7], held_red_reg[6:0]});

    // First stage: scaled luma and chroma.
    always_ff @(posedge aclk) begin
        if (cmd.scale) begin
            y1_reg <= SUM_W'(luma_off) * Y_COEF;
            pb_reg <= SUM_W'(cb_off) * C_COEF;
            pr_reg <= SUM_W'(cr_off) * C_COEF;
        end
    end

    // Second stage: matrix products.
    always_ff @(posedge aclk) begin
        if (cmd.product) begin
            y1d_reg <= y1_reg;
            rcr_reg <= pr_reg * R_CR;
            gcb_reg <= pb_reg * G_CB;
            gcr_reg <= pr_reg * G_CR;
            bcb_reg <= pb_reg * B_CB;
        end
    end

    // Third stage: channel sums, clamp and RGB565 packing.
    assign r_sum = y1d_reg + rcr_reg;
    assign g_sum = y1d_reg - gcb_reg - gcr_reg;
    assign b_sum = y1d_reg + bcb_reg;
    assign r_ch  = to_channel(r_sum);
    assign g_ch  = to_channel(g_sum);
    assign b_ch  = to_channel(b_sum);

    always_ff @(posedge aclk) begin
        if (cmd.sum) begin
            pix_reg <= {r_ch[7:3], g_ch[7:2], b_ch[7:3]};
        end
    end

    assign rgb_pixel = pix_reg;
    assign line_done = last_copy & eol_reg;

endmodule

FILE: hdl/yrz_controller.sv
module yrz_controller
    import yrz_pkg::*;
(
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              cfg_valid,
    output logic              cfg_ready,
    input  logic [ZOOM_W-1:0] cfg_data,
    input  logic              s_valid,
    output logic              s_ready,
    output logic              m_valid,
    input  logic              m_ready,
    output logic              last_copy,
    output yrz_cmd_t          cmd
);

    localparam logic [2:0] ST_IDLE    = 3'd0;
    localparam logic [2:0] ST_SCALE   = 3'd1;
    localparam logic [2:0] ST_PRODUCT = 3'd2;
    localparam logic [2:0] ST_SUM     = 3'd3;
    localparam logic [2:0] ST_EMIT    = 3'd4;

    logic [2:0]        state_reg, state_next;
    logic [ZOOM_W-1:0] zoom_reg;
    logic [COPY_W-1:0] copies_reg, copies_next;
    logic [COPY_W-1:0] count_reg, count_next;
    logic              in_fire, out_fire;

    // Zoom register: writes are always taken.
    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            zoom_reg <= ZOOM_W'(1);
        end else if (cfg_valid) begin
            zoom_reg <= cfg_data;
        end
    end

    // Copy count for the next pixel: zero reads as one, large values saturate.
    always_comb begin
        if (zoom_reg == '0) begin
            copies_next = COPY_W'(1);
        end else if ({1'b0, zoom_reg} > (ZOOM_W + 1)'(MAX_ZOOM)) begin
            copies_next = COPY_W'(MAX_ZOOM);
        end else begin
            copies_next = COPY_W'(zoom_reg);
        end
    end

    assign s_ready   = (state_reg == ST_IDLE);
    assign m_valid   = (state_reg == ST_EMIT);
    assign in_fire   = s_valid & s_ready;
    assign out_fire  = m_valid & m_ready;
    assign last_copy = m_valid && (count_reg == copies_reg - COPY_W'(1));

    assign cmd.load    = in_fire;
    assign cmd.scale   = (state_reg == ST_SCALE);
    assign cmd.product = (state_reg == ST_PRODUCT);
    assign cmd.sum     = (state_reg == ST_SUM);

    // Sequencer: one word through the stages, then its copies.
    always_comb begin
        state_next = state_reg;
        count_next = count_reg;
        unique case (state_reg)
            ST_IDLE: begin
                if (in_fire) begin
                    state_next = ST_SCALE;
                    count_next = '0;
                end
            end
            ST_SCALE:   state_next = ST_PRODUCT;
            ST_PRODUCT: state_next = ST_SUM;
            ST_SUM:     state_next = ST_EMIT;
            ST_EMIT: begin
                if (out_fire) begin
                    if (last_copy) begin
                        state_next = ST_IDLE;
                    end else begin
                        count_next = count_reg + COPY_W'(1);
                    end
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg  <= ST_IDLE;
            count_reg  <= '0;
            copies_reg <= COPY_W'(1);
        end else begin
            state_reg <= state_next;
            count_reg <= count_next;
            if (in_fire) begin
                copies_reg <= copies_next;
            end
        end
    end

    // A word is never taken while copies are still going out.
    a_no_overlap: assert property (@(posedge aclk) disable iff (!aresetn)
        !(s_ready && m_valid))
        else $error("input and output sides active together");

    // The copy counter stays below the copy count.
    a_count_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (count_reg < copies_reg))
        else $error("copy counter beyond copy count");

    // Taking the final copy returns the block to accepting words.
    a_last_returns: assert property (@(posedge aclk) disable iff (!aresetn)
        (out_fire && last_copy) |=> s_ready)
        else $error("block not ready after final copy");

    // An accepted word reaches the output once the scale, product and sum states have passed.
    a_latency: assert property (@(posedge aclk) disable iff (!aresetn)
        in_fire |=> ##3 m_valid)
        else $error("pipeline latency broken");

endmodule

FILE: tb/sv/testbench.sv
module testbench;
    import yrz_pkg::*;

    // Matrix constants: LUMA_GAIN has 20 fractional bits, the chroma gains 10 each.
    localparam longint LUMA_GAIN   = 1225732;
    localparam longint CHROMA_GAIN = 1170;
    localparam longint RED_FROM_CR = 1436;
    localparam longint GRN_FROM_CB = 352;
    localparam longint GRN_FROM_CR = 731;
    localparam longint BLU_FROM_CB = 1815;
    localparam longint LUMA_BLACK  = 16;
    localparam longint CHROMA_MID  = 128;
    localparam int     MAX_REPORTS = 10;
    localparam int     TAIL_CYCLES = 4 + MAX_ZOOM + 4;

    typedef struct {
        logic [15:0] rgb;
        logic        last_copy;
        logic        line_done;
    } rgb_copy_t;

    // Tracks the converter's state and holds the copies still to come out.
    class pixel_scoreboard;
        logic [ZOOM_W-1:0] zoom;
        bit                odd_column;
        logic [7:0]        held_blue;
        logic [7:0]        held_red;
        rgb_copy_t         copies_due[$];
        int                failures;

        function new();
            zoom       = 1;
            odd_column = 0;
            held_blue  = 0;
            held_red   = 0;
            failures   = 0;
        endfunction

        function void set_zoom(logic [ZOOM_W-1:0] value);
            zoom = value;
        endfunction

        function int pending();
            return copies_due.size();
        endfunction

        function void log_failure(string msg);
            if (failures < MAX_REPORTS) begin
                $display("[%0t] %s", $realtime, msg);
            end
            failures++;
        endfunction

        // Shift out the fraction and clamp to an 8-bit channel.
        function logic [7:0] to_channel(longint sum);
            longint whole;
            whole = sum >>> 20;
            if (sum < 0) return 8'd0;
            if (whole > 255) return 8'd255;
            return whole[7:0];
        endfunction

        // Called for every accepted word: converts it and queues zoom copies.
        function void note_pixel(logic [7:0] luma, logic [7:0] cb, logic [7:0] cr,
                                 logic eol);
            longint    y_val;
            longint    cb_val;
            longint    cr_val;
            longint    y_term;
            longint    pb;
            longint    pr;
            logic [7:0] red;
            logic [7:0] green;
            logic [7:0] blue;
            int        count;
            rgb_copy_t item;

            // Chroma is latched on even columns only.
            if (!odd_column) begin
                held_blue = cb;
                held_red  = cr;
            end
            y_val  = luma;
            cb_val = held_blue;
            cr_val = held_red;
            y_term = (y_val - LUMA_BLACK) * LUMA_GAIN;
            pb     = (cb_val - CHROMA_MID) * CHROMA_GAIN;
            pr     = (cr_val - CHROMA_MID) * CHROMA_GAIN;
            red    = to_channel(y_term + RED_FROM_CR * pr);
            green  = to_channel(y_term - GRN_FROM_CB * pb - GRN_FROM_CR * pr);
            blue   = to_channel(y_term + BLU_FROM_CB * pb);
            odd_column = eol ? 1'b0 : !odd_column;

            // A zoom of zero still gives one copy; large values saturate.
            count = zoom;
            if (count < 1) count = 1;
            if (count > MAX_ZOOM) count = MAX_ZOOM;
            for (int k = 0; k < count; k++) begin
                item.rgb       = {red[7:3], green[7:2], blue[7:3]};
                item.last_copy = (k == count - 1);
                item.line_done = (k == count - 1) && eol;
                copies_due.push_back(item);
            end
        endfunction

        // Compares one output word with the oldest expected copy.
        function void check_copy(logic [15:0] rgb, logic last_copy, logic line_done);
            rgb_copy_t want;
            if (copies_due.size() == 0) begin
                log_failure($sformatf("unexpected output word: pixel %h last %b line %b",
                                      rgb, last_copy, line_done));
                return;
            end
            want = copies_due.pop_front();
            if (want.rgb !== rgb || want.last_copy !== last_copy ||
                want.line_done !== line_done) begin
                log_failure($sformatf(
                    "mismatch: expected pixel %h last %b line %b, got pixel %h last %b line %b",
                    want.rgb, want.last_copy, want.line_done, rgb, last_copy, line_done));
            end
        endfunction

        // Every copy still outstanding at the end counts as a failure.
        function int close_out();
            rgb_copy_t want;
            while (copies_due.size() != 0) begin
                want = copies_due.pop_front();
                log_failure($sformatf("missing output word: pixel %h last %b line %b",
                                      want.rgb, want.last_copy, want.line_done));
            end
            return failures;
        endfunction
    endclass

    logic              aclk;
    logic              aresetn;
    logic              cfg_valid;
    logic              cfg_ready;
    logic [ZOOM_W-1:0] cfg_data;
    logic              s_valid;
    logic              s_ready;
    logic [7:0]        s_luma;
    logic [7:0]        s_chroma_blue;
    logic [7:0]        s_chroma_red;
    logic              s_end_of_line;
    logic              m_valid;
    logic              m_ready = 1'b0;
    logic [15:0]       m_rgb_pixel;
    logic              m_last_copy;
    logic              m_line_done;

    pixel_scoreboard sb = new();
    int              send_idle_pct  = 0;
    int              recv_stall_pct = 0;

    ycbcr_to_rgb565_zoom_top u_dut (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_data      (cfg_data),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_luma        (s_luma),
        .s_chroma_blue (s_chroma_blue),
        .s_chroma_red  (s_chroma_red),
        .s_end_of_line (s_end_of_line),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_rgb_pixel   (m_rgb_pixel),
        .m_last_copy   (m_last_copy),
        .m_line_done   (m_line_done)
    );

    initial begin
        aclk = 1'b0;
        forever #6 aclk = ~aclk;
    end

    // Receiver back-pressure, redrawn every cycle.
    always @(posedge aclk) begin
        m_ready <= ($urandom_range(99) >= recv_stall_pct);
    end

    // Every output word taken by the receiver is checked.
    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready) begin
            sb.check_copy(m_rgb_pixel, m_last_copy, m_line_done);
        end
    end

    initial begin
        #12000000;
        $display("TEST FAILED");
        $finish;
    end

    // Presents one pixel word, after a random gap when send_idle_pct allows one, and holds it until taken.
    task automatic send_pixel(input logic [7:0] luma, input logic [7:0] cb,
                              input logic [7:0] cr, input logic eol);
        if ($urandom_range(99) < send_idle_pct) begin
            s_valid <= 1'b0;
            do @(posedge aclk); while ($urandom_range(99) < send_idle_pct);
        end
        s_valid       <= 1'b1;
        s_luma        <= luma;
        s_chroma_blue <= cb;
        s_chroma_red  <= cr;
        s_end_of_line <= eol;
        do @(posedge aclk); while (!s_ready);
        sb.note_pixel(luma, cb, cr, eol);
    endtask

    task automatic drop_valid();
        s_valid <= 1'b0;
    endtask

    // Waits until every expected copy has come out and the block has settled.
    task automatic wait_idle();
        while (sb.pending() != 0) @(posedge aclk);
        repeat (3) @(posedge aclk);
    endtask

    task automatic write_zoom(input logic [ZOOM_W-1:0] value);
        cfg_valid <= 1'b1;
        cfg_data  <= value;
        do @(posedge aclk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        sb.set_zoom(value);
    endtask

    function automatic logic [7:0] pick_sample();
        case ($urandom_range(7))
            0: return 8'd0;
            1: return 8'd255;
            default: return 8'($urandom_range(255));
        endcase
    endfunction

    // One random phase: mostly whole lines of random length, with some stray
    // end-of-line flags mixed in. A non-zero pause_at drains the block mid-phase.
    task automatic run_phase(input int items, input logic [ZOOM_W-1:0] zoom_value,
                             input int idle_pct, input int stall_pct, input int pause_at);
        int sent;
        int line_len;
        logic eol;
        drop_valid();
        wait_idle();
        write_zoom(zoom_value);
        send_idle_pct  = idle_pct;
        recv_stall_pct = stall_pct;
        sent = 0;
        while (sent < items) begin
            line_len = $urandom_range(12, 1);
            for (int k = 0; k < line_len && sent < items; k++) begin
                if ($urandom_range(9) == 0) eol = 1'($urandom_range(1));
                else eol = (k == line_len - 1);
                send_pixel(pick_sample(), pick_sample(), pick_sample(), eol);
                sent++;
                if (sent == pause_at) begin
                    drop_valid();
                    wait_idle();
                end
            end
        end
    endtask

    initial begin
        int failures;
        cfg_valid     <= 1'b0;
        cfg_data      <= '0;
        s_valid       <= 1'b0;
        s_luma        <= '0;
        s_chroma_blue <= '0;
        s_chroma_red  <= '0;
        s_end_of_line <= 1'b0;
        aresetn       <= 1'b0;
        repeat (8) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Directed words at the reset zoom of one: neutral grey, odd-column chroma
        // that must be ignored, full-scale extremes, and end of line on both parities.
        send_pixel(8'd16, 8'd128, 8'd128, 1'b0);
        send_pixel(8'd235, 8'd0, 8'd255, 1'b0);
        send_pixel(8'd0, 8'd0, 8'd0, 1'b0);
        send_pixel(8'd255, 8'd255, 8'd255, 1'b1);
        send_pixel(8'd255, 8'd0, 8'd255, 1'b1);
        send_pixel(8'd0, 8'd255, 8'd0, 1'b0);
        send_pixel(8'd128, 8'd77, 8'd200, 1'b1);

        // A zoom of zero still gives one copy.
        drop_valid();
        wait_idle();
        write_zoom(4'd0);
        send_pixel(8'd81, 8'd90, 8'd240, 1'b0);
        send_pixel(8'd145, 8'd54, 8'd34, 1'b1);

        // The largest register value saturates at the copy limit.
        drop_valid();
        wait_idle();
        write_zoom(4'd15);
        send_pixel(8'd41, 8'd240, 8'd110, 1'b0);
        send_pixel(8'd255, 8'd255, 8'd0, 1'b0);
        send_pixel(8'd0, 8'd0, 8'd255, 1'b1);

        drop_valid();
        wait_idle();
        write_zoom(4'(MAX_ZOOM));
        send_pixel(8'd210, 8'd16, 8'd146, 1'b0);
        send_pixel(8'd170, 8'd166, 8'd16, 1'b1);

        drop_valid();
        wait_idle();
        write_zoom(4'd2);
        send_pixel(8'd255, 8'd128, 8'd128, 1'b0);
        send_pixel(8'd0, 8'd128, 8'd128, 1'b1);

        // Random phases with different pacing on each side.
        run_phase(85, 4'($urandom_range(3, 1)), 0, 0, 0);
        run_phase(85, 4'($urandom_range(15)), 63, 0, 40);
        run_phase(85, 4'($urandom_range(15)), 0, 63, 0);
        run_phase(85, 4'($urandom_range(15)), 27, 27, 0);

        drop_valid();
        while (sb.pending() != 0) @(posedge aclk);
        repeat (TAIL_CYCLES) @(posedge aclk);
        failures = sb.close_out();
        if (failures == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end

endmodule

FILE: files.f
hdl/yrz_pkg.sv
hdl/yrz_datapath.sv
hdl/yrz_controller.sv
hdl/ycbcr_to_rgb565_zoom_top.sv
tb/sv/testbench.sv
